[src/bfc_pkg.sv]
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and opcode constants for the branch flow classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

    // Flow class codes
    typedef enum logic [2:0] {
        FK_NORMAL  = 3'd0,
        FK_HALT    = 3'd1,
        FK_JUMP    = 3'd2,
        FK_CALL    = 3'd3,
        FK_RETURN  = 3'd4,
        FK_RESTART = 3'd5
    } t_flow_class;

    // Branch condition codes
    typedef enum logic [3:0] {
        BC_NONE = 4'd0,
        BC_NZ   = 4'd1,
        BC_Z    = 4'd2,
        BC_NC   = 4'd3,
        BC_C    = 4'd4,
        BC_PO   = 4'd5,
        BC_PE   = 4'd6,
        BC_P    = 4'd7,
        BC_M    = 4'd8,
        BC_DJNZ = 4'd9
    } t_branch_cond;

    // Opcodes and decode masks
    localparam logic [7:0] OP_DJNZ     = 8'h10;
    localparam logic [7:0] OP_JR       = 8'h18;
    localparam logic [7:0] OP_JR_NZ    = 8'h20;
    localparam logic [7:0] OP_JR_Z     = 8'h28;
    localparam logic [7:0] OP_JR_NC    = 8'h30;
    localparam logic [7:0] OP_JR_C     = 8'h38;
    localparam logic [7:0] OP_JP       = 8'hC3;
    localparam logic [7:0] OP_CALL     = 8'hCD;
    localparam logic [7:0] OP_RET      = 8'hC9;
    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_JP_IND   = 8'hE9;
    localparam logic [7:0] OP_PFX_IX   = 8'hDD;
    localparam logic [7:0] OP_PFX_IY   = 8'hFD;
    localparam logic [7:0] OP_PFX_ED   = 8'hED;
    localparam logic [7:0] OP_RETN     = 8'h45;
    localparam logic [7:0] OP_RETI     = 8'h4D;
    localparam logic [7:0] CC_MASK     = 8'hC7;
    localparam logic [7:0] CC_JP       = 8'hC2;
    localparam logic [7:0] CC_CALL     = 8'hC4;
    localparam logic [7:0] CC_RET      = 8'hC0;
    localparam logic [7:0] CC_RST      = 8'hC7;
    localparam logic [7:0] RST_VEC     = 8'h38;

    // One instruction request
    typedef struct packed {
        logic [15:0] instr_addr;
        logic [2:0]  instr_length;
        logic [7:0]  opcode_byte;
        logic [7:0]  second_byte;
        logic [7:0]  third_byte;
        logic        hl_known;
        logic [15:0] hl_value;
        logic        ix_known;
        logic [15:0] ix_value;
        logic        iy_known;
        logic [15:0] iy_value;
    } t_bfc_req;

    // One classification result
    typedef struct packed {
        t_flow_class  flow_class;
        t_branch_cond branch_cond;
        logic [15:0]  fallthrough_addr;
        logic [15:0]  target_addr;
        logic         target_valid;
    } t_bfc_rsp;

endpackage

`default_nettype wire

[src/bfc_if.sv]
// ----------------------------------------------------------------------------
// bfc_if
// Valid/ready channels for instruction requests and classification results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfc_req_if;
    logic              valid;
    logic              ready;
    bfc_pkg::t_bfc_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bfc_rsp_if;
    logic              valid;
    logic              ready;
    bfc_pkg::t_bfc_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/branch_flow_classifier_unit.sv]
// ----------------------------------------------------------------------------
// branch_flow_classifier_unit
// Control-flow classifier for one decoded Z80 instruction per request.
// ----------------------------------------------------------------------------
// The unit takes one instruction request per cycle and returns its flow kind,
// branch condition, fall-through address and branch target: on acceptance the
// request is captured in an input register, then decoded by a short
// combinational classifier and captured in a result register. Both
// stages advance independently, so a new request is taken every cycle while
// the result side is draining; a stalled result holds the pipeline only once
// both stages are full. Sustained rate is one request per clock while results are taken.
`default_nettype none

module branch_flow_classifier_unit (
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    bfc_req_if.sink   i_in,
    bfc_rsp_if.source o_out
);

    logic              r_s1_valid;
    bfc_pkg::t_bfc_req r_s1_req;
    logic              r_out_valid;
    bfc_pkg::t_bfc_rsp r_out_rsp;
    bfc_pkg::t_bfc_rsp n_out_rsp;
    logic              s1_ready;
    logic              s2_ready;

    // Stage ready chain
    assign s2_ready   = !r_out_valid || o_out.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign i_in.ready = s1_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1_req <= i_in.payload;
        end
    end

    // Classifier
    bfc_decode u_decode (
        .i_req (r_s1_req),
        .o_rsp (n_out_rsp)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_rsp;

    // Checks
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> r_s1_valid)
        else $error("input stage dropped a blocked request");

    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s1_valid)
        else $error("accepted request did not reach input stage");

    a_no_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.target_valid) |->
            (o_out.payload.target_addr == 16'd0))
        else $error("target address nonzero without valid target");

    a_target_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.target_valid) |->
            (o_out.payload.flow_class == bfc_pkg::FK_JUMP ||
             o_out.payload.flow_class == bfc_pkg::FK_CALL ||
             o_out.payload.flow_class == bfc_pkg::FK_RESTART))
        else $error("target reported for a flow kind without one");

    a_djnz_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.branch_cond == bfc_pkg::BC_DJNZ) |->
            (o_out.payload.flow_class == bfc_pkg::FK_JUMP))
        else $error("djnz condition on a non-jump");

endmodule

`default_nettype wire

[src/bfc_decode.sv]
// ----------------------------------------------------------------------------
// bfc_decode
// Combinational control-flow decode of one registered instruction request.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_decode (
    input  var bfc_pkg::t_bfc_req i_req,
    output var bfc_pkg::t_bfc_rsp o_rsp
);

    logic [7:0]  op;
    logic [7:0]  b1;
    logic [15:0] fall;
    logic [15:0] rel;
    logic [15:0] absv;
    logic [3:0]  cc_full;
    logic [3:0]  cc_short;

    // Address arithmetic, all modulo 2^16
    assign op       = i_req.opcode_byte;
    assign b1       = i_req.second_byte;
    assign fall     = i_req.instr_addr + {13'd0, i_req.instr_length};
    assign rel      = fall + {{8{b1[7]}}, b1};
    assign absv     = {i_req.third_byte, b1};
    assign cc_full  = {1'b0, op[5:3]} + 4'd1;
    assign cc_short = {2'b00, op[4:3]} + 4'd1;

    // Opcode classification, first match wins
    always_comb begin
        o_rsp                  = '0;
        o_rsp.flow_class       = bfc_pkg::FK_NORMAL;
        o_rsp.branch_cond      = bfc_pkg::BC_NONE;
        o_rsp.fallthrough_addr = fall;
        o_rsp.target_addr      = '0;
        o_rsp.target_valid     = 1'b0;
        if (op == bfc_pkg::OP_DJNZ) begin
            o_rsp.flow_class   = bfc_pkg::FK_JUMP;
            o_rsp.branch_cond  = bfc_pkg::BC_DJNZ;
            o_rsp.target_addr  = rel;
            o_rsp.target_valid = 1'b1;
        end else if (op == bfc_pkg::OP_JR) begin
            o_rsp.flow_class   = bfc_pkg::FK_JUMP;
            o_rsp.target_addr  = rel;
            o_rsp.target_valid = 1'b1;
        end else if (op == bfc_pkg::OP_JR_NZ || op == bfc_pkg::OP_JR_Z ||
                     op == bfc_pkg::OP_JR_NC || op == bfc_pkg::OP_JR_C) begin
            o_rsp.flow_class   = bfc_pkg::FK_JUMP;
            o_rsp.branch_cond  = bfc_pkg::t_branch_cond'(cc_short);
            o_rsp.target_addr  = rel;
            o_rsp.target_valid = 1'b1;
        end else if (op == bfc_pkg::OP_JP) begin
            o_rsp.flow_class   = bfc_pkg::FK_JUMP;
            o_rsp.target_addr  = absv;
            o_rsp.target_valid = 1'b1;
        end else if ((op & bfc_pkg::CC_MASK) == bfc_pkg::CC_JP) begin
            o_rsp.flow_class   = bfc_pkg::FK_JUMP;
            o_rsp.branch_cond  = bfc_pkg::t_branch_cond'(cc_full);
            o_rsp.target_addr  = absv;
            o_rsp.target_valid = 1'b1;
        end else if (op == bfc_pkg::OP_CALL) begin
            o_rsp.flow_class   = bfc_pkg::FK_CALL;
            o_rsp.target_addr  = absv;
            o_rsp.target_valid = 1'b1;
        end else if ((op & bfc_pkg::CC_MASK) == bfc_pkg::CC_CALL) begin
            o_rsp.flow_class   = bfc_pkg::FK_CALL;
            o_rsp.branch_cond  = bfc_pkg::t_branch_cond'(cc_full);
            o_rsp.target_addr  = absv;
            o_rsp.target_valid = 1'b1;
        end else if ((op & bfc_pkg::CC_MASK) == bfc_pkg::CC_RET) begin
            o_rsp.flow_class   = bfc_pkg::FK_RETURN;
            o_rsp.branch_cond  = bfc_pkg::t_branch_cond'(cc_full);
        end else if (op == bfc_pkg::OP_RET) begin
            o_rsp.flow_class   = bfc_pkg::FK_RETURN;
        end else if (op == bfc_pkg::OP_HALT) begin
            o_rsp.flow_class   = bfc_pkg::FK_HALT;
        end else if ((op & bfc_pkg::CC_MASK) == bfc_pkg::CC_RST) begin
            o_rsp.flow_class   = bfc_pkg::FK_RESTART;
            o_rsp.target_addr  = {8'd0, op & bfc_pkg::RST_VEC};
            o_rsp.target_valid = 1'b1;
        end else if (op == bfc_pkg::OP_JP_IND) begin
            // JP (HL): target only when HL is known
            o_rsp.flow_class   = bfc_pkg::FK_JUMP;
            o_rsp.target_valid = i_req.hl_known;
            o_rsp.target_addr  = i_req.hl_known ? i_req.hl_value : 16'd0;
        end else if (op == bfc_pkg::OP_PFX_IX) begin
            if (b1 == bfc_pkg::OP_JP_IND) begin
                o_rsp.flow_class   = bfc_pkg::FK_JUMP;
                o_rsp.target_valid = i_req.ix_known;
                o_rsp.target_addr  = i_req.ix_known ? i_req.ix_value : 16'd0;
            end
        end else if (op == bfc_pkg::OP_PFX_IY) begin
            if (b1 == bfc_pkg::OP_JP_IND) begin
                o_rsp.flow_class   = bfc_pkg::FK_JUMP;
                o_rsp.target_valid = i_req.iy_known;
                o_rsp.target_addr  = i_req.iy_known ? i_req.iy_value : 16'd0;
            end
        end else if (op == bfc_pkg::OP_PFX_ED) begin
            // RETN / RETI
            if (b1 == bfc_pkg::OP_RETN || b1 == bfc_pkg::OP_RETI) begin
                o_rsp.flow_class = bfc_pkg::FK_RETURN;
            end
        end
    end

endmodule

`default_nettype wire

[tb/branch_flow_classifier_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_flow_classifier_unit_tb
// Self-checking bench for the Z80 branch flow classifier. It runs a directed
// table of instructions first: the obvious rows carry hand-typed results and
// the rest go through the bench's own classifier. A random instruction mix
// follows in four traffic phases, with sender gaps, receiver stalls, a long
// receiver hold-off and a full drain between phases. Every result is compared
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------

module branch_flow_classifier_unit_tb;

    import bfc_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PHASE_ITEMS   = 500;
    localparam int          HOLD_CYCLES   = 60;
    localparam int          SETTLE_CYCLES = 10;
    localparam logic [7:0]  OP_NOP        = 8'h00;

    logic clk;
    logic rst_n;

    bfc_req_if req_ch ();
    bfc_rsp_if rsp_ch ();

    branch_flow_classifier_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    // Predicted results, oldest first
    t_bfc_rsp    pending_results[$];
    int          mismatch_count;
    int          cycle_count;
    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;
    int          stall_hold;

    // Hand-typed result traveling with the request being offered
    logic        pinned_valid;
    t_bfc_rsp    pinned_result;

    // Directed rows
    t_bfc_req    dir_req[$];
    bit          dir_pinned[$];
    t_bfc_rsp    dir_result[$];

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("branch_flow_classifier_unit_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Classifier: flow kind, condition, fall-through and target of one
    // instruction request
    // ------------------------------------------------------------------------
    function automatic t_bfc_rsp classify_instr(input t_bfc_req r);
        t_bfc_rsp    res;
        logic [7:0]  op;
        logic [15:0] rel_tgt;
        logic [15:0] abs_tgt;
        logic [15:0] tgt;
        logic        has_tgt;
        op                   = r.opcode_byte;
        res.flow_class       = FK_NORMAL;
        res.branch_cond      = BC_NONE;
        // length is added as given, even outside 1..4
        res.fallthrough_addr = r.instr_addr + {13'd0, r.instr_length};
        // relative targets always count from the fall-through address
        rel_tgt              = res.fallthrough_addr + {{8{r.second_byte[7]}}, r.second_byte};
        abs_tgt              = {r.third_byte, r.second_byte};
        tgt                  = '0;
        has_tgt              = 1'b0;

        if (op == OP_DJNZ) begin
            res.flow_class  = FK_JUMP;
            res.branch_cond = BC_DJNZ;
            tgt             = rel_tgt;
            has_tgt         = 1'b1;
        end else if (op == OP_JR) begin
            res.flow_class = FK_JUMP;
            tgt            = rel_tgt;
            has_tgt        = 1'b1;
        end else if (op == OP_JR_NZ || op == OP_JR_Z || op == OP_JR_NC || op == OP_JR_C) begin
            res.flow_class  = FK_JUMP;
            res.branch_cond = t_branch_cond'({2'b00, op[4:3]} + 4'd1);
            tgt             = rel_tgt;
            has_tgt         = 1'b1;
        end else if (op == OP_JP) begin
            res.flow_class = FK_JUMP;
            tgt            = abs_tgt;
            has_tgt        = 1'b1;
        end else if ((op & CC_MASK) == CC_JP) begin
            res.flow_class  = FK_JUMP;
            res.branch_cond = t_branch_cond'({1'b0, op[5:3]} + 4'd1);
            tgt             = abs_tgt;
            has_tgt         = 1'b1;
        end else if (op == OP_CALL) begin
            res.flow_class = FK_CALL;
            tgt            = abs_tgt;
            has_tgt        = 1'b1;
        end else if ((op & CC_MASK) == CC_CALL) begin
            res.flow_class  = FK_CALL;
            res.branch_cond = t_branch_cond'({1'b0, op[5:3]} + 4'd1);
            tgt             = abs_tgt;
            has_tgt         = 1'b1;
        end else if ((op & CC_MASK) == CC_RET) begin
            res.flow_class  = FK_RETURN;
            res.branch_cond = t_branch_cond'({1'b0, op[5:3]} + 4'd1);
        end else if (op == OP_RET) begin
            res.flow_class = FK_RETURN;
        end else if (op == OP_HALT) begin
            res.flow_class = FK_HALT;
        end else if ((op & CC_MASK) == CC_RST) begin
            res.flow_class = FK_RESTART;
            tgt            = {8'h00, op & RST_VEC};
            has_tgt        = 1'b1;
        end else if (op == OP_JP_IND) begin
            res.flow_class = FK_JUMP;
            tgt            = r.hl_value;
            has_tgt        = r.hl_known;
        end else if (op == OP_PFX_IX) begin
            if (r.second_byte == OP_JP_IND) begin
                res.flow_class = FK_JUMP;
                tgt            = r.ix_value;
                has_tgt        = r.ix_known;
            end
        end else if (op == OP_PFX_IY) begin
            if (r.second_byte == OP_JP_IND) begin
                res.flow_class = FK_JUMP;
                tgt            = r.iy_value;
                has_tgt        = r.iy_known;
            end
        end else if (op == OP_PFX_ED) begin
            if (r.second_byte == OP_RETN || r.second_byte == OP_RETI) begin
                res.flow_class = FK_RETURN;
            end
        end

        // an unknown register value never leaks into the target
        res.target_addr  = has_tgt ? tgt : 16'h0000;
        res.target_valid = has_tgt;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Helpers for building rows and random requests
    // ------------------------------------------------------------------------
    function automatic t_bfc_req instr_of(input logic [15:0] addr, input logic [2:0] len,
                                          input logic [7:0] op, input logic [7:0] b1,
                                          input logic [7:0] b2);
        t_bfc_req r;
        r              = '0;
        r.instr_addr   = addr;
        r.instr_length = len;
        r.opcode_byte  = op;
        r.second_byte  = b1;
        r.third_byte   = b2;
        return r;
    endfunction

    function automatic t_bfc_rsp rsp_of(input t_flow_class kind, input t_branch_cond cond,
                                        input logic [15:0] fall, input logic [15:0] tgt,
                                        input logic valid);
        t_bfc_rsp s;
        s.flow_class       = kind;
        s.branch_cond      = cond;
        s.fallthrough_addr = fall;
        s.target_addr      = tgt;
        s.target_valid     = valid;
        return s;
    endfunction

    task automatic add_row(input t_bfc_req r, input bit pinned, input t_bfc_rsp s);
        dir_req    = {dir_req, r};
        dir_pinned = {dir_pinned, pinned};
        dir_result = {dir_result, s};
    endtask

    // Mostly branch-family opcodes with random operands, some raw bytes
    function automatic t_bfc_req random_instr();
        t_bfc_req   r;
        logic [7:0] cc_bits;
        cc_bits        = {2'b00, 3'($urandom_range(7)), 3'b000};
        r.instr_addr   = 16'($urandom_range(16'hFFFF));
        r.instr_length = 3'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                     : $urandom_range(4, 1));
        r.second_byte  = 8'($urandom_range(255));
        r.third_byte   = 8'($urandom_range(255));
        r.hl_known     = 1'($urandom_range(1));
        r.hl_value     = 16'($urandom_range(16'hFFFF));
        r.ix_known     = 1'($urandom_range(1));
        r.ix_value     = 16'($urandom_range(16'hFFFF));
        r.iy_known     = 1'($urandom_range(1));
        r.iy_value     = 16'($urandom_range(16'hFFFF));
        case ($urandom_range(11))
            0, 1, 2: r.opcode_byte = 8'($urandom_range(255));
            3: begin
                case ($urandom_range(5))
                    0:       r.opcode_byte = OP_DJNZ;
                    1:       r.opcode_byte = OP_JR;
                    2:       r.opcode_byte = OP_JR_NZ;
                    3:       r.opcode_byte = OP_JR_Z;
                    4:       r.opcode_byte = OP_JR_NC;
                    default: r.opcode_byte = OP_JR_C;
                endcase
            end
            4: r.opcode_byte = CC_JP | cc_bits;
            5: r.opcode_byte = CC_CALL | cc_bits;
            6: r.opcode_byte = CC_RET | cc_bits;
            7: r.opcode_byte = CC_RST | cc_bits;
            8: begin
                case ($urandom_range(4))
                    0:       r.opcode_byte = OP_JP;
                    1:       r.opcode_byte = OP_CALL;
                    2:       r.opcode_byte = OP_RET;
                    3:       r.opcode_byte = OP_HALT;
                    default: r.opcode_byte = OP_JP_IND;
                endcase
            end
            9: begin
                r.opcode_byte = OP_PFX_IX;
                if ($urandom_range(9) < 6) r.second_byte = OP_JP_IND;
            end
            10: begin
                r.opcode_byte = OP_PFX_IY;
                if ($urandom_range(9) < 6) r.second_byte = OP_JP_IND;
            end
            default: begin
                r.opcode_byte = OP_PFX_ED;
                if ($urandom_range(9) < 6)
                    r.second_byte = $urandom_range(1) ? OP_RETN : OP_RETI;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: optional idle gap, then hold the request until taken
    // ------------------------------------------------------------------------
    task automatic offer_request(input t_bfc_req r, input bit pinned, input t_bfc_rsp s);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        pinned_valid   <= pinned;
        pinned_result  <= s;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Result receiver: long hold-off when requested, else random stalls
    always @(negedge clk) begin
        if (stall_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_hold--;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each field with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_result(input t_bfc_rsp want, input t_bfc_rsp got);
        if (got.flow_class !== want.flow_class) begin
            $error("flow_class: expected %0d, got %0d", want.flow_class, got.flow_class);
            mismatch_count++;
        end
        if (got.branch_cond !== want.branch_cond) begin
            $error("branch_cond: expected %0d, got %0d", want.branch_cond, got.branch_cond);
            mismatch_count++;
        end
        if (got.fallthrough_addr !== want.fallthrough_addr) begin
            $error("fallthrough_addr: expected %h, got %h",
                   want.fallthrough_addr, got.fallthrough_addr);
            mismatch_count++;
        end
        if (got.target_addr !== want.target_addr) begin
            $error("target_addr: expected %h, got %h", want.target_addr, got.target_addr);
            mismatch_count++;
        end
        if (got.target_valid !== want.target_valid) begin
            $error("target_valid: expected %0d, got %0d", want.target_valid, got.target_valid);
            mismatch_count++;
        end
    endtask

    // Check results first, then record newly accepted requests
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no pending request: flow_class %0d target %h",
                           rsp_ch.payload.flow_class, rsp_ch.payload.target_addr);
                    mismatch_count++;
                end else begin
                    check_result(pending_results[0], rsp_ch.payload);
                    pending_results.delete(0);
                end
            end
            if (req_ch.valid && req_ch.ready)
                pending_results = {pending_results,
                                   pinned_valid ? pinned_result
                                                : classify_instr(req_ch.payload)};
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_bfc_req r;
        mismatch_count  = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        stall_hold      = 0;
        pinned_valid    = 1'b0;
        pinned_result   = '0;
        req_ch.valid    = 1'b0;
        req_ch.payload  = '0;
        rsp_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: extremes, every instruction family, special cases
        add_row(instr_of(16'h0000, 3'd1, OP_NOP, 8'h00, 8'h00), 1,
                rsp_of(FK_NORMAL, BC_NONE, 16'h0001, 16'h0000, 1'b0));
        add_row(instr_of(16'hFFFF, 3'd1, OP_HALT, 8'h00, 8'h00), 1,
                rsp_of(FK_HALT, BC_NONE, 16'h0000, 16'h0000, 1'b0));
        add_row(instr_of(16'h1000, 3'd2, OP_DJNZ, 8'h7F, 8'h00), 1,
                rsp_of(FK_JUMP, BC_DJNZ, 16'h1002, 16'h1081, 1'b1));
        // most negative displacement wraps below zero
        add_row(instr_of(16'h0000, 3'd2, OP_JR, 8'h80, 8'h00), 1,
                rsp_of(FK_JUMP, BC_NONE, 16'h0002, 16'hFF82, 1'b1));
        add_row(instr_of(16'h8000, 3'd2, OP_JR_NZ, 8'hFE, 8'h00), 0, '0);
        add_row(instr_of(16'h7FFF, 3'd2, OP_JR_Z, 8'h01, 8'h00), 0, '0);
        add_row(instr_of(16'h1234, 3'd2, OP_JR_NC, 8'hFF, 8'h00), 0, '0);
        add_row(instr_of(16'hFFFE, 3'd2, OP_JR_C, 8'h7F, 8'hFF), 0, '0);
        add_row(instr_of(16'hFFFE, 3'd3, OP_JP, 8'h34, 8'h12), 1,
                rsp_of(FK_JUMP, BC_NONE, 16'h0001, 16'h1234, 1'b1));
        add_row(instr_of(16'h2000, 3'd3, CC_JP | 8'h20, 8'hCD, 8'hAB), 0, '0);
        add_row(instr_of(16'h0000, 3'd3, CC_JP | 8'h38, 8'hFF, 8'hFF), 1,
                rsp_of(FK_JUMP, BC_M, 16'h0003, 16'hFFFF, 1'b1));
        add_row(instr_of(16'h0100, 3'd3, OP_CALL, 8'h00, 8'h00), 1,
                rsp_of(FK_CALL, BC_NONE, 16'h0103, 16'h0000, 1'b1));
        add_row(instr_of(16'hABCD, 3'd3, CC_CALL | 8'h28, 8'h55, 8'hAA), 0, '0);
        add_row(instr_of(16'h0050, 3'd1, OP_RET, 8'h00, 8'h00), 1,
                rsp_of(FK_RETURN, BC_NONE, 16'h0051, 16'h0000, 1'b0));
        add_row(instr_of(16'h0050, 3'd1, CC_RET | 8'h38, 8'hFF, 8'hFF), 0, '0);
        add_row(instr_of(16'h3000, 3'd1, CC_RST | RST_VEC, 8'h00, 8'h00), 1,
                rsp_of(FK_RESTART, BC_NONE, 16'h3001, 16'h0038, 1'b1));
        add_row(instr_of(16'h3000, 3'd1, CC_RST, 8'hFF, 8'hFF), 1,
                rsp_of(FK_RESTART, BC_NONE, 16'h3001, 16'h0000, 1'b1));
        // indirect jumps, register known and unknown
        r = instr_of(16'h4000, 3'd1, OP_JP_IND, 8'h00, 8'h00);
        r.hl_known = 1'b1;
        r.hl_value = 16'hFFFF;
        add_row(r, 1, rsp_of(FK_JUMP, BC_NONE, 16'h4001, 16'hFFFF, 1'b1));
        r.hl_known = 1'b0;
        r.hl_value = 16'hBEEF;
        add_row(r, 1, rsp_of(FK_JUMP, BC_NONE, 16'h4001, 16'h0000, 1'b0));
        r = instr_of(16'h5000, 3'd2, OP_PFX_IX, OP_JP_IND, 8'h00);
        r.ix_known = 1'b1;
        r.ix_value = 16'hA5A5;
        add_row(r, 0, '0);
        r = instr_of(16'h5000, 3'd2, OP_PFX_IY, OP_JP_IND, 8'h00);
        r.hl_known = 1'b1;
        r.ix_known = 1'b1;
        r.iy_value = 16'h5A5A;
        add_row(r, 0, '0);
        // prefixes followed by something else fall back to normal
        add_row(instr_of(16'h5000, 3'd4, OP_PFX_IX, 8'h21, 8'h34), 0, '0);
        add_row(instr_of(16'h6000, 3'd2, OP_PFX_ED, OP_RETN, 8'h00), 1,
                rsp_of(FK_RETURN, BC_NONE, 16'h6002, 16'h0000, 1'b0));
        add_row(instr_of(16'h6000, 3'd2, OP_PFX_ED, OP_RETI, 8'h00), 0, '0);
        add_row(instr_of(16'h6000, 3'd2, OP_PFX_ED, 8'h46, 8'h00), 0, '0);
        // lengths outside 1..4 are added as given
        add_row(instr_of(16'h1234, 3'd0, OP_JR, 8'h00, 8'h00), 1,
                rsp_of(FK_JUMP, BC_NONE, 16'h1234, 16'h1234, 1'b1));
        add_row(instr_of(16'hFFFC, 3'd7, OP_DJNZ, 8'hFC, 8'h00), 1,
                rsp_of(FK_JUMP, BC_DJNZ, 16'h0003, 16'hFFFF, 1'b1));

        foreach (dir_req[i])
            offer_request(dir_req[i], dir_pinned[i], dir_result[i]);
        drain_results();

        // Random traffic in four phases of idling
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 76;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 76;
                end
                default: begin
                    sender_idle_pct = 25;
                    recv_stall_pct  = 25;
                end
            endcase
            // long receiver hold-off so the pipeline backs up into the input
            if (phase == 0 || phase == 3)
                stall_hold = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_request(random_instr(), 1'b0, '0);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("branch_flow_classifier_unit_tb passed");
        else
            $display("branch_flow_classifier_unit_tb failed");
        $finish;
    end

endmodule
